@@ rtl/sstfq_pkg.sv @@
// Package for the shortest-seek-time-first request queue.
// It holds the default sizes, the command and status codes and the cell control struct.
// It depends on nothing else.
package sstfq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int SECTOR_BITS_DEF = 48;
  localparam int TAG_BITS_DEF    = 8;
  localparam int OCC_BITS        = 6;

  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Control that the sequencer sends to every cell in the row.
  typedef struct packed {
    logic start;  // a new walk begins at the front
    logic ins;    // a cell has found the insertion point in this cycle
    logic pop;    // remove the front entry, everything moves one place forward
  } cell_ctrl_t;

endpackage

@@ rtl/sstfq_cell.sv @@
// One place of the request queue: stored sector and tag, a walk token and a passed flag.
// It depends on sstfq_pkg.
module sstfq_cell import sstfq_pkg::*; #(
  parameter int SECTOR_BITS = SECTOR_BITS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctrl_t             ctrl,
  input  logic                   occupied,
  input  logic                   tok_in,
  input  logic [SECTOR_BITS-1:0] ref_sector,
  input  logic [SECTOR_BITS-1:0] left_sector,
  input  logic [TAG_BITS-1:0]    left_tag,
  input  logic [SECTOR_BITS-1:0] right_sector,
  input  logic [TAG_BITS-1:0]    right_tag,
  input  logic [SECTOR_BITS-1:0] new_sector,
  input  logic [TAG_BITS-1:0]    new_tag,
  output logic [SECTOR_BITS-1:0] sector,
  output logic [TAG_BITS-1:0]    tag,
  output logic                   tok_out,
  output logic                   hit
);

  logic                   tok;
  logic                   passed;
  logic [SECTOR_BITS-1:0] dist_new;
  logic [SECTOR_BITS-1:0] dist_old;

  always_comb begin
    dist_new = (new_sector >= ref_sector) ? (new_sector - ref_sector)
                                          : (ref_sector - new_sector);
    dist_old = (sector >= ref_sector) ? (sector - ref_sector) : (ref_sector - sector);
  end

  // An empty place always takes the new request: that is the tail.
  assign hit     = tok && (!occupied || (dist_new < dist_old));
  assign tok_out = tok && !hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok    <= 1'b0;
      passed <= 1'b0;
    end else begin
      tok <= tok_in;
      if (ctrl.start) begin
        passed <= 1'b0;
      end else if (tok_out) begin
        passed <= 1'b1;
      end
    end
  end

  // Places the token has not reached yet move one step back on an insertion.
  always_ff @(posedge clk) begin
    if (ctrl.ins && tok) begin
      sector <= new_sector;
      tag    <= new_tag;
    end else if (ctrl.ins && !passed) begin
      sector <= left_sector;
      tag    <= left_tag;
    end else if (ctrl.pop) begin
      sector <= right_sector;
      tag    <= right_tag;
    end
  end

endmodule

@@ rtl/sstf_request_queue.sv @@
// Shortest-seek-time-first request queue: top level with sequencer and a row of cells.
// It depends on sstfq_pkg and sstfq_cell.
//
// Usage. Commands arrive on the request channel (req_valid, req_stall); a transfer
// happens at a clock edge with req_valid high and req_stall low. Each command gives
// exactly one result on the response channel (rsp_valid, rsp_stall), held in an
// output register until its transfer completes.
// An add walks the queue front to back, one cell per cycle, with a token; the
// reference point of each cell is the sector of the cell in front of it, or the
// head sector for the front cell. The first cell whose entry lies strictly farther
// from its reference than the new request does (or the first empty cell) takes the
// request, and every cell behind it moves one place back in the same cycle.
// The walk through the cell row sets how long an add takes, as its result waits
// until the token reaches the place it lands in; rejected adds and dispatches skip
// the walk and go from idle straight to the hold state.
// A new command is taken while a result still waits in the output register; if the
// receiver stalls, the following result waits in a pending register and the block
// takes nothing more until the output register frees.
// Synchronous reset empties the queue and drops any result in flight; the stored
// sectors and tags are not cleared, as only occupied places are ever read.
module sstf_request_queue import sstfq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int SECTOR_BITS = SECTOR_BITS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic                   command,
  input  logic [SECTOR_BITS-1:0] request_sector,
  input  logic [TAG_BITS-1:0]    request_tag,
  input  logic [SECTOR_BITS-1:0] head_sector,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic [1:0]             status,
  output logic [SECTOR_BITS-1:0] dispatched_sector,
  output logic [TAG_BITS-1:0]    dispatched_tag,
  output logic [OCC_BITS-1:0]    occupancy
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [SECTOR_BITS-1:0] new_sector;
  logic [TAG_BITS-1:0]    new_tag;
  logic [SECTOR_BITS-1:0] head;
  status_t                res_status;
  logic [SECTOR_BITS-1:0] res_sector;
  logic [TAG_BITS-1:0]    res_tag;
  logic [CNT_W-1:0]       res_count;

  logic                   req_take;
  logic                   full;
  logic                   empty;
  logic                   out_free;
  logic                   any_hit;
  cell_ctrl_t             ctrl;

  logic [SECTOR_BITS-1:0] cell_sector [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    cell_tag    [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_tok;
  logic [QUEUE_DEPTH-1:0] cell_hit;
  logic [QUEUE_DEPTH-1:0] cell_occ;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign any_hit   = |cell_hit;

  assign ctrl.start = req_take && (command == CMD_ADD) && !full;
  assign ctrl.ins   = (state == S_WALK) && any_hit;
  assign ctrl.pop   = req_take && (command == CMD_DISPATCH) && !empty;

  // The row of cells. The front cell's reference is the head sector; every other
  // cell takes the sector of the cell in front of it as reference.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                   tok_left;
    logic [SECTOR_BITS-1:0] ref_sec;
    logic [SECTOR_BITS-1:0] left_sec;
    logic [TAG_BITS-1:0]    left_tg;
    logic [SECTOR_BITS-1:0] right_sec;
    logic [TAG_BITS-1:0]    right_tg;

    assign cell_occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_front
      assign tok_left = ctrl.start;
      assign ref_sec  = head;
      assign left_sec = new_sector;
      assign left_tg  = new_tag;
    end else begin : g_inner
      assign tok_left = cell_tok[i-1];
      assign ref_sec  = cell_sector[i-1];
      assign left_sec = cell_sector[i-1];
      assign left_tg  = cell_tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_back
      assign right_sec = cell_sector[i];
      assign right_tg  = cell_tag[i];
    end else begin : g_mid
      assign right_sec = cell_sector[i+1];
      assign right_tg  = cell_tag[i+1];
    end

    sstfq_cell #(
      .SECTOR_BITS(SECTOR_BITS),
      .TAG_BITS   (TAG_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .occupied    (cell_occ[i]),
      .tok_in      (tok_left),
      .ref_sector  (ref_sec),
      .left_sector (left_sec),
      .left_tag    (left_tg),
      .right_sector(right_sec),
      .right_tag   (right_tg),
      .new_sector  (new_sector),
      .new_tag     (new_tag),
      .sector      (cell_sector[i]),
      .tag         (cell_tag[i]),
      .tok_out     (cell_tok[i]),
      .hit         (cell_hit[i])
    );
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    count_next = count;
    unique case (state)
      S_IDLE: begin
        if (ctrl.start) begin
          state_next = S_WALK;
        end else if (req_take) begin
          state_next = S_HOLD;
          if (ctrl.pop) begin
            count_next = count - 1'b1;
          end
        end
      end
      S_WALK: begin
        if (any_hit) begin
          state_next = S_HOLD;
          count_next = count + 1'b1;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if ((state == S_HOLD) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: the captured request, the pending result and the output.
  always_ff @(posedge clk) begin
    if (req_take) begin
      new_sector <= request_sector;
      new_tag    <= request_tag;
      head       <= head_sector;
      res_sector <= '0;
      res_tag    <= '0;
      res_count  <= count;
      if (command == CMD_ADD) begin
        res_status <= full ? ST_FULL : ST_DONE;
      end else if (empty) begin
        res_status <= ST_EMPTY;
      end else begin
        res_status <= ST_DONE;
        res_sector <= cell_sector[0];
        res_tag    <= cell_tag[0];
        res_count  <= count - 1'b1;
      end
    end else if (ctrl.ins) begin
      res_count <= count + 1'b1;
    end

    if ((state == S_HOLD) && out_free) begin
      status            <= res_status;
      dispatched_sector <= res_sector;
      dispatched_tag    <= res_tag;
      occupancy         <= OCC_BITS'(res_count);
    end
  end

endmodule

@@ rtl/sstfq_checker.sv @@
// Port-level checks for the shortest-seek-time-first request queue, bound to the top level.
// It depends on sstfq_pkg and sstf_request_queue.
module sstfq_checker import sstfq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int SECTOR_BITS = SECTOR_BITS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   rsp_valid,
  input logic                   rsp_stall,
  input logic [1:0]             status,
  input logic [SECTOR_BITS-1:0] dispatched_sector,
  input logic [TAG_BITS-1:0]    dispatched_tag,
  input logic [OCC_BITS-1:0]    occupancy
);

  // No result survives a reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result shown after reset");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
      $stable(dispatched_sector) && $stable(dispatched_tag) && $stable(occupancy))
    else $error("stalled result changed");

  // A rejected add or an empty dispatch carries no sector and no tag.
  a_no_data: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && (status != ST_DONE) |-> (dispatched_sector == '0) && (dispatched_tag == '0))
    else $error("sector or tag on a result that is no dispatch");

  // A rejected add means a full queue, an empty dispatch an empty one.
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && (status == ST_FULL) |-> occupancy == OCC_BITS'(QUEUE_DEPTH))
    else $error("add rejected with queue not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && (status == ST_EMPTY) |-> occupancy == '0)
    else $error("empty dispatch with queue not empty");

endmodule

bind sstf_request_queue sstfq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH),
  .SECTOR_BITS(SECTOR_BITS),
  .TAG_BITS   (TAG_BITS)
) u_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp_valid),
  .rsp_stall        (rsp_stall),
  .status           (status),
  .dispatched_sector(dispatched_sector),
  .dispatched_tag   (dispatched_tag),
  .occupancy        (occupancy)
);

@@ tb/tb_sstf_request_queue.sv @@
// Self-checking testbench for sstf_request_queue, the shortest-seek-time-first queue.
// It holds a scoreboard class that predicts each response and the tasks that drive the block.
// It depends on sstfq_pkg and on the RTL of sstf_request_queue.
`timescale 1ns / 100ps

module tb_sstf_request_queue import sstfq_pkg::*;;

  localparam int SECTOR_W     = SECTOR_BITS_DEF;
  localparam int TAG_W        = TAG_BITS_DEF;
  localparam int RANDOM_ITEMS = 950;
  localparam int REPORT_LIMIT = 10;
  // The slowest correct transfer costs the walk of the whole row, a long sender gap
  // and a long receiver stall. A thousand of those come to about 1.2 ms, so the
  // watchdog sits several times above that.
  localparam int RUN_LIMIT_NS = 6_000_000;

  localparam logic [SECTOR_W-1:0] SECTOR_MAX = '1;
  localparam logic [SECTOR_W-1:0] SECTOR_MID = {1'b1, {(SECTOR_W-1){1'b0}}};

  // Traffic shapes for the random part. Fill blocks push the queue up to its depth
  // so that refused adds happen, drain blocks empty it again so that dispatches hit
  // an empty queue, and even blocks exercise the mixture in between.
  typedef enum int {TRAFFIC_FILL, TRAFFIC_DRAIN, TRAFFIC_EVEN} traffic_t;

  // Scoreboard: keeps its own copy of the queue, predicts the response of every
  // command at the moment its transfer is accepted and compares the responses, in
  // order, against those predictions.
  class seek_order_scoreboard;

    typedef struct packed {
      status_t               status;
      logic [SECTOR_W-1:0]   sector;
      logic [TAG_W-1:0]      tag;
      logic [OCC_BITS-1:0]   occupancy;
    } seek_result_t;

    logic [SECTOR_W-1:0] queued_sectors[$];
    logic [TAG_W-1:0]    queued_tags[$];
    seek_result_t        awaited[$];

    int commands;
    int adds_placed;
    int front_inserts;
    int tie_walks;
    int adds_refused;
    int dispatches;
    int empty_dispatches;
    int peak_fill;
    int responses_checked;
    int failures;

    function logic [SECTOR_W-1:0] seek_distance(logic [SECTOR_W-1:0] a, logic [SECTOR_W-1:0] b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function void record_failure(string what);
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("%0t ns: %s", $time, what);
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // Works out the response of one accepted command and updates the queue copy.
    function void note_command(logic cmd, logic [SECTOR_W-1:0] sec, logic [TAG_W-1:0] tag,
                               logic [SECTOR_W-1:0] head);
      seek_result_t        result;
      logic [SECTOR_W-1:0] refp;
      int                  slot;
      result = '0;
      result.status = ST_DONE;
      commands++;
      if (cmd == CMD_ADD) begin
        if (queued_sectors.size() >= QUEUE_DEPTH_DEF) begin
          result.status = ST_FULL;
          adds_refused++;
        end else begin
          // The reference point starts at the head and then follows each entry
          // that the new request does not overtake.
          refp = head;
          slot = queued_sectors.size();
          for (int i = 0; i < queued_sectors.size(); i++) begin
            if (seek_distance(sec, refp) < seek_distance(queued_sectors[i], refp)) begin
              slot = i;
              break;
            end
            if (seek_distance(sec, refp) == seek_distance(queued_sectors[i], refp))
              tie_walks++;
            refp = queued_sectors[i];
          end
          if (slot < queued_sectors.size())
            front_inserts++;
          queued_sectors.insert(slot, sec);
          queued_tags.insert(slot, tag);
          adds_placed++;
        end
      end else begin
        if (queued_sectors.size() == 0) begin
          result.status = ST_EMPTY;
          empty_dispatches++;
        end else begin
          result.sector = queued_sectors.pop_front();
          result.tag    = queued_tags.pop_front();
          dispatches++;
        end
      end
      result.occupancy = OCC_BITS'(queued_sectors.size());
      if (queued_sectors.size() > peak_fill)
        peak_fill = queued_sectors.size();
      awaited.push_back(result);
    endfunction

    // Compares one accepted response with the oldest prediction.
    function void check_response(logic [1:0] st, logic [SECTOR_W-1:0] sec, logic [TAG_W-1:0] tag,
                                 logic [OCC_BITS-1:0] occ);
      seek_result_t want;
      if (awaited.size() == 0) begin
        record_failure($sformatf("response with nothing outstanding: status %0d sector %h tag %h",
                                 st, sec, tag));
        return;
      end
      want = awaited.pop_front();
      responses_checked++;
      if (st !== want.status || sec !== want.sector || tag !== want.tag ||
          occ !== want.occupancy)
        record_failure($sformatf({"response %0d differs: expected status %0d sector %h tag %h ",
                                  "occupancy %0d, got status %0d sector %h tag %h occupancy %0d"},
                                 responses_checked, want.status, want.sector, want.tag,
                                 want.occupancy, st, sec, tag, occ));
    endfunction

    function void close_out();
      if (awaited.size() != 0)
        record_failure($sformatf("%0d responses never arrived", awaited.size()));
    endfunction

  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic                command = CMD_ADD;
  logic [SECTOR_W-1:0] request_sector = '0;
  logic [TAG_W-1:0]    request_tag = '0;
  logic [SECTOR_W-1:0] head_sector = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [1:0]          status;
  logic [SECTOR_W-1:0] dispatched_sector;
  logic [TAG_W-1:0]    dispatched_tag;
  logic [OCC_BITS-1:0] occupancy;

  seek_order_scoreboard board;

  // While calm is set neither side inserts gaps, so the block sees back-to-back
  // transfers on both channels for a while.
  bit calm = 1'b0;
  int stall_left = 0;

  always #5 clk = ~clk;

  sstf_request_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH_DEF),
    .SECTOR_BITS(SECTOR_BITS_DEF),
    .TAG_BITS   (TAG_BITS_DEF)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .command          (command),
    .request_sector   (request_sector),
    .request_tag      (request_tag),
    .head_sector      (head_sector),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .status           (status),
    .dispatched_sector(dispatched_sector),
    .dispatched_tag   (dispatched_tag),
    .occupancy        (occupancy)
  );

  // Idle length for either side: mostly none, otherwise short, and now and then a long
  // one that can outlast a full walk of the queue.
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    if (roll < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sectors either spread over the whole range, so that every bit toggles, or gather
  // near zero, near the top and near the middle, where distances are small and ties
  // are common. Clustered blocks keep every sector between 0 and 15.
  function automatic logic [SECTOR_W-1:0] pick_sector(bit cluster);
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    if (cluster)
      return SECTOR_W'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0:       return wide[SECTOR_W-1:0];
      1:       return SECTOR_W'($urandom_range(0, 63));
      2:       return SECTOR_MAX - SECTOR_W'($urandom_range(0, 63));
      default: return SECTOR_MID + SECTOR_W'(wide[6:0]) - SECTOR_W'(64);
    endcase
  endfunction

  // Presents one command and waits for its transfer. The task starts just after the
  // clock rises; valid is only lowered when a gap is wanted, so a command that follows
  // straight on keeps valid high, as valid is only set once more in that step.
  // Stall and valid are read just after the edge, before the block updates them.
  task automatic send_command(input logic cmd, input logic [SECTOR_W-1:0] sec,
                              input logic [TAG_W-1:0] tag, input logic [SECTOR_W-1:0] head);
    int gap;
    gap = calm ? 0 : pick_idle();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid      <= 1'b1;
    command        <= cmd;
    request_sector <= sec;
    request_tag    <= tag;
    head_sector    <= head;
    do @(posedge clk); while (req_stall !== 1'b0);
    board.note_command(cmd, sec, tag, head);
  endtask

  // Receiving side: checks each response transfer and stalls in random bursts.
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0)
      board.check_response(status, dispatched_sector, dispatched_tag, occupancy);
    if (stall_left != 0) begin
      rsp_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      rsp_stall <= 1'b0;
      if (!calm && !rst)
        stall_left = pick_idle();
    end
  end

  initial begin
    traffic_t traffic;
    bit       cluster;
    int       sent;
    int       block_len;
    int       add_pct;
    logic     cmd;
    board = new();
    sent  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed opening. A dispatch on the empty queue comes first, then the field
    // extremes, including a head at the top of the range with requests at the very
    // bottom, where only a true absolute difference gives the right order.
    send_command(CMD_DISPATCH, SECTOR_MAX, '1, SECTOR_MAX);
    send_command(CMD_ADD, '0, '0, '0);
    send_command(CMD_ADD, SECTOR_MAX, '1, SECTOR_MAX);
    send_command(CMD_ADD, SECTOR_MID, TAG_W'(8'h3c), '0);
    send_command(CMD_DISPATCH, '0, '0, '0);
    send_command(CMD_DISPATCH, '0, '0, '0);
    send_command(CMD_DISPATCH, '0, '0, '0);
    send_command(CMD_ADD, '0, TAG_W'(8'h5a), SECTOR_MAX);
    send_command(CMD_ADD, SECTOR_W'(1), TAG_W'(8'ha5), SECTOR_MAX);
    send_command(CMD_DISPATCH, '0, '0, '0);
    send_command(CMD_DISPATCH, '0, '0, '0);

    // Equal distances: 110 sits as far from 100 as 90 does, so it must pass 90 and
    // go to the tail, while 95 is nearer to 100 than 90 is and slips in before it.
    send_command(CMD_ADD, SECTOR_W'(100), TAG_W'(1), SECTOR_W'(100));
    send_command(CMD_ADD, SECTOR_W'(90), TAG_W'(2), SECTOR_W'(100));
    send_command(CMD_ADD, SECTOR_W'(110), TAG_W'(3), SECTOR_W'(100));
    send_command(CMD_ADD, SECTOR_W'(95), TAG_W'(4), SECTOR_W'(100));
    repeat (5) send_command(CMD_DISPATCH, pick_sector(1'b0), TAG_W'($urandom), '1);

    // Random part in blocks of one traffic shape each. The first block fills the
    // queue so that refused adds are seen early.
    traffic = TRAFFIC_FILL;
    while (sent < RANDOM_ITEMS) begin
      block_len = $urandom_range(30, 70);
      calm      = ($urandom_range(0, 3) == 0);
      cluster   = ($urandom_range(0, 2) == 0);
      case (traffic)
        TRAFFIC_FILL:  add_pct = 90;
        TRAFFIC_DRAIN: add_pct = 12;
        default:       add_pct = 55;
      endcase
      for (int k = 0; k < block_len && sent < RANDOM_ITEMS; k++) begin
        cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_DISPATCH;
        send_command(cmd, pick_sector(cluster), TAG_W'($urandom), pick_sector(cluster));
        sent++;
      end
      traffic = traffic_t'($urandom_range(0, 2));
    end
    req_valid <= 1'b0;
    calm = 1'b0;

    // Let the outstanding responses drain, then give the block time to show any
    // stray response before the books are closed.
    for (int w = 0; w < 5000 && board.outstanding() != 0; w++)
      @(posedge clk);
    repeat (QUEUE_DEPTH_DEF + 8) @(posedge clk);
    board.close_out();

    $display("Ran %0d commands: %0d adds placed (%0d ahead of older entries, %0d equal-distance passes), %0d refused on a full queue.",
             board.commands, board.adds_placed, board.front_inserts, board.tie_walks,
             board.adds_refused);
    $display("Dispatched %0d requests, %0d dispatches met an empty queue, peak fill %0d, %0d responses compared.",
             board.dispatches, board.empty_dispatches, board.peak_fill,
             board.responses_checked);
    if (board.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d failures in total", board.failures);
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #RUN_LIMIT_NS;
    $display("Watchdog expired with %0d responses outstanding", board.outstanding());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
